FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define AHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising clock edge, reset included.
`define AHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ahp_pkg.sv
// Shared types, constants and codes for the altitude hold PID block.
`timescale 1ns / 1ps

package ahp_pkg;

  // Field and state widths.
  localparam int SIG_W     = 32;   // Q16.16 signals
  localparam int INT_W     = 48;   // integrator
  localparam int PID_W     = 56;   // saturated PID terms and sum
  localparam int SUM_W     = PID_W + 2;
  localparam int DIFF_W    = PID_W + 1;
  localparam int ERR_W     = SIG_W + 1;
  localparam int MUL_W     = 33;   // multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int LO_W      = 32;   // low chunk of a split operand
  localparam int MAC_W     = DIFF_W + MUL_W;
  localparam int GAIN_SH   = 24;   // Q8.24 gains
  localparam int WG_SH     = 16;   // Q16.16 windup gain
  localparam int TERM_W    = PROD_W - GAIN_SH;
  localparam int CORR_W    = MAC_W - WG_SH;
  localparam int MARGIN    = 655;  // 0.01 m in Q16.16

  localparam int DECAY_W   = 25;
  localparam int UGAIN_W   = 31;

  localparam int IDX_W     = 3;
  localparam int CDATA_W   = 32;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_WEIGHT = 3'd2,
    REG_DERIV_DECAY  = 3'd3,
    REG_DERIV_SCALE  = 3'd4,
    REG_WINDUP_GAIN  = 3'd5,
    REG_PITCH_LIMIT  = 3'd6,
    REG_HOLD_BAND    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0]        prop_gain;
    logic signed [31:0]        integ_gain;
    logic signed [31:0]        deriv_weight;
    logic [DECAY_W-1:0]        deriv_decay;
    logic [UGAIN_W-1:0]        deriv_scale;
    logic signed [31:0]        windup_gain;
    logic [UGAIN_W-1:0]        pitch_limit;
    logic [UGAIN_W-1:0]        hold_band;
  } ahp_cfg_t;

  // Register values after reset.
  localparam logic signed [31:0]  RST_PROP_GAIN    = 32'sd251658;
  localparam logic signed [31:0]  RST_INTEG_GAIN   = 32'sd252;
  localparam logic signed [31:0]  RST_DERIV_WEIGHT = 32'sd0;
  localparam logic [DECAY_W-1:0]  RST_DERIV_DECAY  = 25'd16773860;
  localparam logic [UGAIN_W-1:0]  RST_DERIV_SCALE  = 31'd335510;
  localparam logic signed [31:0]  RST_WINDUP_GAIN  = 32'sd43690667;
  localparam logic [UGAIN_W-1:0]  RST_PITCH_LIMIT  = 31'd22877;
  localparam logic [UGAIN_W-1:0]  RST_HOLD_BAND    = 31'd655360;

  // Multiplier operand pairs; the _HI pairs take the upper chunk of a wide operand.
  typedef enum logic [2:0] {
    MS_FD_DECAY,
    MS_DE_SCALE,
    MS_E_KP,
    MS_INT_LO,
    MS_INT_HI,
    MS_FD_KD,
    MS_DIFF_LO,
    MS_DIFF_HI
  } mul_sel_t;

  // Datapath register updates.
  typedef enum logic [3:0] {
    CAP_NONE,
    CAP_ERR,
    CAP_ZONE,
    CAP_INTEG,
    CAP_FDT,
    CAP_FD,
    CAP_UP,
    CAP_UI,
    CAP_UD,
    CAP_SAT,
    CAP_CLIP,
    CAP_WB,
    CAP_CLEAR
  } cap_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_ZONE,
    ST_INTEG,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_SAT,
    ST_CLIP,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_WB,
    ST_OUT,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     issue;
    mul_sel_t sel;
    cap_t     cap;
    logic     load_out;
  } ahp_cmd_t;

  typedef struct packed {
    logic out_free;
  } ahp_sts_t;

endpackage

FILE: hdl/ahp_cfg.sv
// Configuration register file of the altitude hold PID block.
`timescale 1ns / 1ps

module ahp_cfg
  import ahp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output ahp_cfg_t           cfg_o
);

  ahp_cfg_t cfg_r, cfg_nxt;
  reg_idx_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = reg_idx_t'(cfg_index);
  assign cfg_o     = cfg_r;

  // Decode one register write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (idx)
        REG_PROP_GAIN:    cfg_nxt.prop_gain    = $signed(cfg_data);
        REG_INTEG_GAIN:   cfg_nxt.integ_gain   = $signed(cfg_data);
        REG_DERIV_WEIGHT: cfg_nxt.deriv_weight = $signed(cfg_data);
        REG_DERIV_DECAY:  cfg_nxt.deriv_decay  = cfg_data[DECAY_W-1:0];
        REG_DERIV_SCALE:  cfg_nxt.deriv_scale  = cfg_data[UGAIN_W-1:0];
        REG_WINDUP_GAIN:  cfg_nxt.windup_gain  = $signed(cfg_data);
        REG_PITCH_LIMIT:  cfg_nxt.pitch_limit  = cfg_data[UGAIN_W-1:0];
        REG_HOLD_BAND:    cfg_nxt.hold_band    = cfg_data[UGAIN_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain    <= RST_PROP_GAIN;
      cfg_r.integ_gain   <= RST_INTEG_GAIN;
      cfg_r.deriv_weight <= RST_DERIV_WEIGHT;
      cfg_r.deriv_decay  <= RST_DERIV_DECAY;
      cfg_r.deriv_scale  <= RST_DERIV_SCALE;
      cfg_r.windup_gain  <= RST_WINDUP_GAIN;
      cfg_r.pitch_limit  <= RST_PITCH_LIMIT;
      cfg_r.hold_band    <= RST_HOLD_BAND;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/ahp_ctrl.sv
// Sequencer that steps the PID datapath through one control tick.
`timescale 1ns / 1ps

module ahp_ctrl
  import ahp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tuser,
  output logic     in_tready,
  input  ahp_sts_t sts,
  output ahp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = in_tuser ? ST_CLR : ST_ERR;
      ST_ERR:   state_nxt = ST_ZONE;
      ST_ZONE:  state_nxt = ST_INTEG;
      ST_INTEG: state_nxt = ST_M2;
      ST_M2:    state_nxt = ST_M3;
      ST_M3:    state_nxt = ST_M4;
      ST_M4:    state_nxt = ST_M5;
      ST_M5:    state_nxt = ST_M6;
      ST_M6:    state_nxt = ST_M7;
      ST_M7:    state_nxt = ST_M8;
      ST_M8:    state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = ST_W1;
      ST_W1:    state_nxt = ST_W2;
      ST_W2:    state_nxt = ST_W3;
      ST_W3:    state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_CLR:   state_nxt = ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands. A product issued in one state passes through prod_r and then acc_r,
  // and each capture reads it from acc_r.
  always_comb begin
    in_tready    = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.issue    = 1'b0;
    cmd.sel      = MS_FD_DECAY;
    cmd.cap      = CAP_NONE;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_ERR:   cmd.cap = CAP_ERR;
      ST_ZONE:  cmd.cap = CAP_ZONE;
      ST_INTEG: begin
        cmd.cap   = CAP_INTEG;
        cmd.issue = 1'b1;
        cmd.sel   = MS_FD_DECAY;
      end
      ST_M2: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_DE_SCALE;
      end
      ST_M3: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_E_KP;
        cmd.cap   = CAP_FDT;
      end
      ST_M4: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_INT_LO;
        cmd.cap   = CAP_FD;
      end
      ST_M5: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_INT_HI;
        cmd.cap   = CAP_UP;
      end
      ST_M6: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_FD_KD;
      end
      ST_M7:   cmd.cap = CAP_UI;
      ST_M8:   cmd.cap = CAP_UD;
      ST_SAT:  cmd.cap = CAP_SAT;
      ST_CLIP: cmd.cap = CAP_CLIP;
      ST_W1: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_DIFF_LO;
      end
      ST_W2: begin
        cmd.issue = 1'b1;
        cmd.sel   = MS_DIFF_HI;
      end
      ST_W3:   cmd.cap = CAP_NONE;
      ST_WB:   cmd.cap = CAP_WB;
      ST_OUT:  cmd.load_out = sts.out_free;
      ST_CLR:  cmd.cap = CAP_CLEAR;
      default: cmd.cap = CAP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/ahp_dp.sv
// PID datapath: error, integrator, derivative filter, shared MAC and output register.
`timescale 1ns / 1ps

module ahp_dp
  import ahp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ahp_cfg_t                cfg,
  input  ahp_cmd_t                cmd,
  output ahp_sts_t                sts,
  input  logic [2*SIG_W-1:0]      in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [SIG_W-1:0]        out_tdata,
  output logic                    out_tuser
);

  // Clip a value to the signed SIG_W range.
  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [TERM_W:0] v);
    logic all_one, all_zero;
    all_one  = &v[TERM_W:SIG_W-1];
    all_zero = ~|v[TERM_W:SIG_W-1];
    if (all_one || all_zero) return v[SIG_W-1:0];
    return v[TERM_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
  endfunction

  // Clip a value to the signed INT_W range.
  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [CORR_W:0] v);
    logic all_one, all_zero;
    all_one  = &v[CORR_W:INT_W-1];
    all_zero = ~|v[CORR_W:INT_W-1];
    if (all_one || all_zero) return v[INT_W-1:0];
    return v[CORR_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
  endfunction

  // Clip a value to the signed PID_W range.
  function automatic logic signed [PID_W-1:0] sat_pid(input logic signed [PROD_W-1:0] v);
    logic all_one, all_zero;
    all_one  = &v[PROD_W-1:PID_W-1];
    all_zero = ~|v[PROD_W-1:PID_W-1];
    if (all_one || all_zero) return v[PID_W-1:0];
    return v[PROD_W-1] ? {1'b1, {(PID_W-1){1'b0}}} : {1'b0, {(PID_W-1){1'b1}}};
  endfunction

  // Input latch and loop state.
  logic signed [SIG_W-1:0]  cmd_alt_r, cmd_alt_nxt, alt_r, alt_nxt;
  logic signed [SIG_W-1:0]  e_r, e_nxt, prev_r, prev_nxt, fd_r, fd_nxt;
  logic signed [ERR_W-1:0]  esum_r, esum_nxt, de_r, de_nxt;
  logic                     zone_r, zone_nxt;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;
  logic signed [TERM_W-1:0] fdt_r, fdt_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PID_W-1:0]  unsat_r, unsat_nxt;
  logic signed [SIG_W-1:0]  clip_r, clip_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic                     satf_r, satf_nxt;

  // Multiply-accumulate pipeline.
  logic signed [MUL_W-1:0]  ma, mb;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r, phi_r;
  logic signed [MAC_W-1:0]  acc_r, acc_nxt;

  // Output register.
  logic                     ov_r, ov_nxt;
  logic signed [SIG_W-1:0]  od_r, od_nxt;
  logic                     os_r, os_nxt;

  // Working values.
  logic signed [ERR_W-1:0]  err_raw, band_s, band_neg, zone_lim, e_ext;
  logic signed [TERM_W-1:0] acc_term;
  logic signed [PID_W-1:0]  lim_s, clip_wide;
  logic                     over_hi, over_lo;

  assign sts.out_free = !ov_r || out_tready;
  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tuser    = os_r;

  assign err_raw  = $signed({cmd_alt_r[SIG_W-1], cmd_alt_r}) - $signed({alt_r[SIG_W-1], alt_r});
  assign band_s   = $signed({2'b00, cfg.hold_band});
  assign band_neg = -band_s;
  assign zone_lim = band_s - ERR_W'(MARGIN);
  assign e_ext    = $signed({e_r[SIG_W-1], e_r});
  assign acc_term = acc_r[PROD_W-1:GAIN_SH];
  assign lim_s    = $signed({{(PID_W-UGAIN_W){1'b0}}, cfg.pitch_limit});
  assign over_hi  = unsat_r > lim_s;
  assign over_lo  = unsat_r < -lim_s;
  assign clip_wide = over_hi ? lim_s : (over_lo ? -lim_s : unsat_r);

  // Multiplier operand selection; wide operands are split into an unsigned
  // low chunk and a signed high chunk.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.sel)
      MS_FD_DECAY: begin
        ma = $signed({fd_r[SIG_W-1], fd_r});
        mb = $signed({{(MUL_W-DECAY_W){1'b0}}, cfg.deriv_decay});
      end
      MS_DE_SCALE: begin
        ma = de_r;
        mb = $signed({{(MUL_W-UGAIN_W){1'b0}}, cfg.deriv_scale});
      end
      MS_E_KP: begin
        ma = $signed({e_r[SIG_W-1], e_r});
        mb = $signed({cfg.prop_gain[31], cfg.prop_gain});
      end
      MS_INT_LO: begin
        ma = $signed({1'b0, integ_r[LO_W-1:0]});
        mb = $signed({cfg.integ_gain[31], cfg.integ_gain});
      end
      MS_INT_HI: begin
        ma = $signed({{(MUL_W-INT_W+LO_W){integ_r[INT_W-1]}}, integ_r[INT_W-1:LO_W]});
        mb = $signed({cfg.integ_gain[31], cfg.integ_gain});
      end
      MS_FD_KD: begin
        ma = $signed({fd_r[SIG_W-1], fd_r});
        mb = $signed({cfg.deriv_weight[31], cfg.deriv_weight});
      end
      MS_DIFF_LO: begin
        ma = $signed({1'b0, diff_r[LO_W-1:0]});
        mb = $signed({cfg.windup_gain[31], cfg.windup_gain});
      end
      MS_DIFF_HI: begin
        ma = $signed({{(MUL_W-DIFF_W+LO_W){diff_r[DIFF_W-1]}}, diff_r[DIFF_W-1:LO_W]});
        mb = $signed({cfg.windup_gain[31], cfg.windup_gain});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Accumulator: a low chunk or single product restarts it, a high chunk
  // adds in shifted up by the low chunk width.
  always_comb begin
    acc_nxt = acc_r;
    if (pv_r) begin
      if (phi_r) begin
        acc_nxt = acc_r + $signed({prod_r[MAC_W-LO_W-1:0], {LO_W{1'b0}}});
      end else begin
        acc_nxt = $signed({{(MAC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
      end
    end
  end

  // Register updates for each step of the tick.
  always_comb begin
    cmd_alt_nxt = cmd_alt_r;
    alt_nxt     = alt_r;
    e_nxt       = e_r;
    prev_nxt    = prev_r;
    fd_nxt      = fd_r;
    esum_nxt    = esum_r;
    de_nxt      = de_r;
    zone_nxt    = zone_r;
    integ_nxt   = integ_r;
    fdt_nxt     = fdt_r;
    sum_nxt     = sum_r;
    unsat_nxt   = unsat_r;
    clip_nxt    = clip_r;
    diff_nxt    = diff_r;
    satf_nxt    = satf_r;
    if (cmd.load_in) begin
      cmd_alt_nxt = $signed(in_tdata[SIG_W-1:0]);
      alt_nxt     = $signed(in_tdata[2*SIG_W-1:SIG_W]);
    end
    case (cmd.cap)
      CAP_NONE: begin
      end
      // Error clamped to the hold band.
      CAP_ERR: begin
        if (err_raw > band_s) begin
          e_nxt = band_s[SIG_W-1:0];
        end else if (err_raw < band_neg) begin
          e_nxt = band_neg[SIG_W-1:0];
        end else begin
          e_nxt = err_raw[SIG_W-1:0];
        end
      end
      // Integration zone test and error sum and difference.
      CAP_ZONE: begin
        zone_nxt = (e_ext > -zone_lim) && (e_ext < zone_lim);
        esum_nxt = e_ext + $signed({prev_r[SIG_W-1], prev_r});
        de_nxt   = e_ext - $signed({prev_r[SIG_W-1], prev_r});
      end
      // Trapezoid step inside the zone, zero outside.
      CAP_INTEG: begin
        if (zone_r) begin
          integ_nxt = sat_int($signed({{(CORR_W+1-INT_W){integ_r[INT_W-1]}}, integ_r})
                      + $signed({{(CORR_W+1-ERR_W){esum_r[ERR_W-1]}}, esum_r}));
        end else begin
          integ_nxt = '0;
        end
      end
      CAP_FDT: fdt_nxt = acc_term;
      // Filtered derivative: decayed old value plus scaled error change.
      CAP_FD: begin
        fd_nxt = sat_sig($signed({fdt_r[TERM_W-1], fdt_r})
                 + $signed({acc_term[TERM_W-1], acc_term}));
      end
      CAP_UP: sum_nxt = $signed({{(SUM_W-TERM_W){acc_term[TERM_W-1]}}, acc_term});
      CAP_UI: begin
        sum_nxt = sum_r + $signed({{(SUM_W-PID_W){1'b0}}, {PID_W{1'b0}}})
                  + SUM_W'(sat_pid(acc_r[MAC_W-1:GAIN_SH]));
      end
      CAP_UD: sum_nxt = sum_r + $signed({{(SUM_W-TERM_W){acc_term[TERM_W-1]}}, acc_term});
      CAP_SAT: unsat_nxt = sat_pid($signed({{(PROD_W-SUM_W){sum_r[SUM_W-1]}}, sum_r}));
      // Output clip and the amount clipped off.
      CAP_CLIP: begin
        clip_nxt = clip_wide[SIG_W-1:0];
        diff_nxt = $signed({clip_wide[PID_W-1], clip_wide})
                   - $signed({unsat_r[PID_W-1], unsat_r});
        satf_nxt = over_hi || over_lo;
      end
      // Back-calculation; a zero windup gain yields a zero correction.
      CAP_WB: begin
        integ_nxt = sat_int($signed({{(CORR_W+1-INT_W){integ_r[INT_W-1]}}, integ_r})
                    + $signed({acc_r[MAC_W-1], acc_r[MAC_W-1:WG_SH]}));
        prev_nxt  = e_r;
      end
      CAP_CLEAR: begin
        integ_nxt = '0;
        fd_nxt    = '0;
        prev_nxt  = '0;
        clip_nxt  = '0;
        satf_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished item waits here until taken.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    os_nxt = os_r;
    if (out_tready) ov_nxt = 1'b0;
    if (cmd.load_out) begin
      ov_nxt = 1'b1;
      od_nxt = clip_r;
      os_nxt = satf_r;
    end
  end

  // Control and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      pv_r    <= 1'b0;
      integ_r <= '0;
      fd_r    <= '0;
      prev_r  <= '0;
    end else begin
      ov_r    <= ov_nxt;
      pv_r    <= cmd.issue;
      integ_r <= integ_nxt;
      fd_r    <= fd_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_alt_r <= cmd_alt_nxt;
    alt_r     <= alt_nxt;
    e_r       <= e_nxt;
    esum_r    <= esum_nxt;
    de_r      <= de_nxt;
    zone_r    <= zone_nxt;
    fdt_r     <= fdt_nxt;
    sum_r     <= sum_nxt;
    unsat_r   <= unsat_nxt;
    clip_r    <= clip_nxt;
    diff_r    <= diff_nxt;
    satf_r    <= satf_nxt;
    prod_r    <= ma * mb;
    phi_r     <= (cmd.sel == MS_INT_HI) || (cmd.sel == MS_DIFF_HI);
    acc_r     <= acc_nxt;
    od_r      <= od_nxt;
    os_r      <= os_nxt;
  end

endmodule

FILE: hdl/altitude_hold_pid_top.sv
// Top level of the altitude hold PID block.
//
//   channel | direction | tdata / data                       | tuser / index
//   in_     | input     | [31:0] altitude_command,           | [0] clear
//           |           | [63:32] altitude                   |
//   out_    | output    | [31:0] pitch_command               | [0] saturated
//   cfg_    | input     | [31:0] register value              | [2:0] register index
//
// The block takes a new item only after the last one has been written to the output
// register; a clear item skips the computation. One shared 33x33 multiplier and its
// accumulator step through eight partial products for each ordinary item.
// rst_n is synchronous and active low; it zeroes the loop state and restores
// the register reset values. A result held by a stalled output blocks the
// next item only when that item's own result is ready to be written.
`timescale 1ns / 1ps

module altitude_hold_pid_top
  import ahp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [2*SIG_W-1:0] in_tdata,   // altitude_command, altitude
  input  logic               in_tuser,   // clear
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [SIG_W-1:0]   out_tdata,  // pitch_command
  output logic               out_tuser,  // saturated
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  ahp_cfg_t cfg;
  ahp_cmd_t cmd;
  ahp_sts_t sts;

  // Register file.
  ahp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Sequencer.
  ahp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  ahp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hdl/ahp_checker.sv
// Port-level checker for the altitude hold PID block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ahp_checker
  import ahp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [SIG_W-1:0]   out_tdata,
  input logic               out_tuser
);

  logic       in_acc, out_acc, out_stall;
  logic [SIG_W:0] out_res;
  logic [1:0] pending_r, pending_nxt;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_res   = {out_tuser, out_tdata};

  // Items accepted whose results are not yet taken.
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) pending_nxt = pending_r + 2'd1;
    if (!in_acc && out_acc) pending_nxt = pending_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `AHP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")
  `AHP_ASSERT(a_one_at_a_time, in_acc |=> !in_tready, "input ready right after an item")
  `AHP_ASSERT(a_result_has_item, out_tvalid |-> pending_r != 2'd0, "result without an item")
  `AHP_ASSERT(a_bounded_backlog, pending_r != 2'd3, "more than two items outstanding")
  `AHP_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_res), "stalled result changed")

endmodule

bind altitude_hold_pid_top ahp_checker u_ahp_checker (.*);

FILE: dv/tb_altitude_hold_pid_top.sv
// Self-checking testbench for the altitude hold PID block: stream driver, result checker, tick predictor.
`timescale 1ns / 1ps

module tb_altitude_hold_pid_top;
  import ahp_pkg::*;

  typedef logic signed [127:0] wide_t;

  // One control tick as it goes into the block.
  typedef struct packed {
    logic signed [SIG_W-1:0] cmd;
    logic signed [SIG_W-1:0] alt;
    logic                    clr;
  } tick_t;

  // One expected pitch result.
  typedef struct packed {
    logic [SIG_W-1:0] pitch;
    logic             sat;
  } pitch_res_t;

  localparam int STALL_LIMIT = 2000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [2*SIG_W-1:0] in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [SIG_W-1:0]   out_tdata;
  logic               out_tuser;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index  = '0;
  logic [CDATA_W-1:0] cfg_data   = '0;

  // Predictor copy of the registers and the loop state.
  ahp_cfg_t                loop_cfg;
  logic signed [INT_W-1:0] integ_acc;
  logic signed [SIG_W-1:0] deriv_filt;
  logic signed [SIG_W-1:0] last_err;

  tick_t      tick_q[$];
  pitch_res_t pitch_expect_q[$];

  int  mismatches = 0;
  int  send_gap   = 0;
  int  recv_gap   = 0;
  int  idle_count = 0;
  bit  quiet      = 1'b0;

  altitude_hold_pid_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Saturate a value to a signed field of w bits.
  function automatic wide_t clamp_w(input wide_t v, input int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Product shifted right with rounding toward minus infinity, saturated to 64 bits.
  function automatic wide_t gain_mul(input wide_t a, input wide_t g, input int sh);
    wide_t p;
    p = (a * g) >>> sh;
    return clamp_w(p, 64);
  endfunction

  // Advance the predicted loop by one tick and return the pitch it should produce.
  function automatic pitch_res_t predict_pitch(input logic signed [SIG_W-1:0] cmd,
                                               input logic signed [SIG_W-1:0] alt,
                                               input logic clr);
    pitch_res_t res;
    wide_t      band;
    wide_t      lim;
    wide_t      e;
    wide_t      prev;
    wide_t      integ;
    wide_t      filt;
    wide_t      up;
    wide_t      ui;
    wide_t      ud;
    wide_t      unsat;
    wide_t      clipped;
    wide_t      corr;
    res = '0;
    if (clr) begin
      integ_acc  = '0;
      deriv_filt = '0;
      last_err   = '0;
      return res;
    end
    band = wide_t'(loop_cfg.hold_band);
    lim  = wide_t'(loop_cfg.pitch_limit);
    prev = wide_t'(last_err);

    // Error clamped to the hold band.
    e = wide_t'(cmd) - wide_t'(alt);
    if (e > band) e = band;
    if (e < -band) e = -band;
    e = clamp_w(e, SIG_W);

    // Trapezoid integration only inside the band less the margin.
    if ((-band + MARGIN < e) && (e < band - MARGIN))
      integ = clamp_w(wide_t'(integ_acc) + e + prev, INT_W);
    else
      integ = 0;

    // Filtered dirty derivative.
    filt = clamp_w(gain_mul(wide_t'(deriv_filt), wide_t'(loop_cfg.deriv_decay), GAIN_SH) +
                   gain_mul(e - prev, wide_t'(loop_cfg.deriv_scale), GAIN_SH), SIG_W);

    // PID terms and output clip.
    up = clamp_w(gain_mul(e, wide_t'($signed(loop_cfg.prop_gain)), GAIN_SH), PID_W);
    ui = clamp_w(gain_mul(integ, wide_t'($signed(loop_cfg.integ_gain)), GAIN_SH), PID_W);
    ud = clamp_w(gain_mul(filt, wide_t'($signed(loop_cfg.deriv_weight)), GAIN_SH), PID_W);
    unsat = clamp_w(up + ui + ud, PID_W);
    clipped = unsat;
    if (clipped > lim) clipped = lim;
    if (clipped < -lim) clipped = -lim;

    // Back-calculation anti-windup.
    if (loop_cfg.windup_gain != 0) begin
      corr  = gain_mul(clipped - unsat, wide_t'($signed(loop_cfg.windup_gain)), WG_SH);
      integ = clamp_w(integ + corr, INT_W);
    end

    integ_acc  = integ[INT_W-1:0];
    deriv_filt = filt[SIG_W-1:0];
    last_err   = e[SIG_W-1:0];
    res.pitch  = clipped[SIG_W-1:0];
    res.sat    = (clipped != unsat);
    return res;
  endfunction

  // Mirror one register write into the predictor.
  function automatic void apply_reg(input reg_idx_t idx, input logic [CDATA_W-1:0] val);
    case (idx)
      REG_PROP_GAIN:    loop_cfg.prop_gain    = val;
      REG_INTEG_GAIN:   loop_cfg.integ_gain   = val;
      REG_DERIV_WEIGHT: loop_cfg.deriv_weight = val;
      REG_DERIV_DECAY:  loop_cfg.deriv_decay  = val[DECAY_W-1:0];
      REG_DERIV_SCALE:  loop_cfg.deriv_scale  = val[UGAIN_W-1:0];
      REG_WINDUP_GAIN:  loop_cfg.windup_gain  = val;
      REG_PITCH_LIMIT:  loop_cfg.pitch_limit  = val[UGAIN_W-1:0];
      REG_HOLD_BAND:    loop_cfg.hold_band    = val[UGAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Write one register through the configuration channel.
  task automatic write_reg(input reg_idx_t idx, input logic [CDATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Load a full register set.
  task automatic program_regs(input ahp_cfg_t c);
    write_reg(REG_PROP_GAIN,    c.prop_gain);
    write_reg(REG_INTEG_GAIN,   c.integ_gain);
    write_reg(REG_DERIV_WEIGHT, c.deriv_weight);
    write_reg(REG_DERIV_DECAY,  CDATA_W'(c.deriv_decay));
    write_reg(REG_DERIV_SCALE,  CDATA_W'(c.deriv_scale));
    write_reg(REG_WINDUP_GAIN,  c.windup_gain);
    write_reg(REG_PITCH_LIMIT,  CDATA_W'(c.pitch_limit));
    write_reg(REG_HOLD_BAND,    CDATA_W'(c.hold_band));
  endtask

  // Wait until every tick is accepted and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || pitch_expect_q.size() != 0);
  endtask

  task automatic add_tick(input logic signed [SIG_W-1:0] cmd,
                          input logic signed [SIG_W-1:0] alt, input logic clr);
    tick_t t;
    t.cmd = cmd;
    t.alt = alt;
    t.clr = clr;
    tick_q.push_back(t);
  endtask

  // Random ticks, mostly errors around the band so the integrator and filter get exercised.
  task automatic add_random(input int n);
    longint band;
    longint span;
    longint delta;
    int     r;
    logic signed [SIG_W-1:0] alt;
    repeat (n) begin
      band = longint'(loop_cfg.hold_band);
      alt  = $urandom;
      r    = $urandom_range(0, 99);
      if (r < 4) begin
        add_tick($urandom, alt, 1'b1);
      end else if (r < 64) begin
        span  = 2 * band + 1024;
        delta = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
        add_tick(alt + SIG_W'(delta), alt, 1'b0);
      end else if (r < 80) begin
        delta = ($urandom_range(0, 1) != 0) ? band - MARGIN : band;
        delta = delta + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) != 0) delta = -delta;
        add_tick(alt + SIG_W'(delta), alt, 1'b0);
      end else begin
        add_tick($urandom, alt, 1'b0);
      end
    end
  endtask

  // Moderate random register set.
  function automatic ahp_cfg_t random_cfg();
    ahp_cfg_t c;
    c.prop_gain    = int'($urandom_range(0, 32'd134217728)) - 67108864;
    c.integ_gain   = int'($urandom_range(0, 32'd2097152)) - 1048576;
    c.deriv_weight = int'($urandom_range(0, 32'd134217728)) - 67108864;
    c.deriv_decay  = DECAY_W'($urandom_range(0, 32'd16777216));
    c.deriv_scale  = UGAIN_W'($urandom_range(0, 32'd67108864));
    c.windup_gain  = ($urandom_range(0, 3) == 0) ? 0 :
                     int'($urandom_range(0, 32'd134217728)) - 67108864;
    c.pitch_limit  = UGAIN_W'($urandom_range(0, 32'd262144));
    c.hold_band    = UGAIN_W'($urandom_range(0, 32'd4194304));
    return c;
  endfunction

  // Input driver: presents queued ticks and predicts each one at acceptance.
  always @(posedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready)
        pitch_expect_q.push_back(predict_pitch(in_tdata[SIG_W-1:0],
                                               in_tdata[2*SIG_W-1:SIG_W], in_tuser));
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0 && !quiet && $urandom_range(0, 3) == 0) begin
          send_gap  <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          nxt = tick_q.pop_front();
          in_tdata  <= {nxt.alt, nxt.cmd};
          in_tuser  <= nxt.clr;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result checker with random back-pressure.
  always @(posedge clk) begin
    pitch_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pitch_expect_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual pitch %0d saturated %0b",
                   $time, $signed(out_tdata), out_tuser);
          mismatches++;
        end else begin
          want = pitch_expect_q.pop_front();
          if (out_tdata !== want.pitch) begin
            $display("%0t: pitch_command mismatch: expected %0d actual %0d",
                     $time, $signed(want.pitch), $signed(out_tdata));
            mismatches++;
          end
          if (out_tuser !== want.sat) begin
            $display("%0t: saturated mismatch: expected %0b actual %0b",
                     $time, want.sat, out_tuser);
            mismatches++;
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_gap   <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    ahp_cfg_t c;
    logic signed [SIG_W-1:0] band;
    loop_cfg.prop_gain    = RST_PROP_GAIN;
    loop_cfg.integ_gain   = RST_INTEG_GAIN;
    loop_cfg.deriv_weight = RST_DERIV_WEIGHT;
    loop_cfg.deriv_decay  = RST_DERIV_DECAY;
    loop_cfg.deriv_scale  = RST_DERIV_SCALE;
    loop_cfg.windup_gain  = RST_WINDUP_GAIN;
    loop_cfg.pitch_limit  = RST_PITCH_LIMIT;
    loop_cfg.hold_band    = RST_HOLD_BAND;
    integ_acc  = '0;
    deriv_filt = '0;
    last_err   = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at the reset settings: field extremes, band and zone edges, clear.
    band = SIG_W'(loop_cfg.hold_band);
    add_tick(32'sh0, 32'sh0, 1'b1);
    add_tick(32'sh0, 32'sh0, 1'b0);
    add_tick(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
    add_tick(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    add_tick(32'sh80000000, 32'sh80000000, 1'b0);
    add_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    add_tick(band - MARGIN, 32'sh0, 1'b0);
    add_tick(band - MARGIN - 1, 32'sh0, 1'b0);
    add_tick(-band + MARGIN, 32'sh0, 1'b0);
    add_tick(-band + MARGIN + 1, 32'sh0, 1'b0);
    add_tick(band, 32'sh0, 1'b0);
    add_tick(band + 1, 32'sh0, 1'b0);
    add_tick(32'sh10000, 32'sh0, 1'b0);
    add_tick(32'sh10000, 32'sh0, 1'b0);
    add_tick(32'sh10000, 32'sh0, 1'b0);
    add_tick(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
    add_tick(32'sh7FFFFFFF, 32'sh0, 1'b0);
    add_tick(32'sh0, 32'sh80000000, 1'b0);
    add_random(100);
    drain();

    // Every register at its top value but the derivative decay, which is set to 1.0.
    c.prop_gain    = 32'sh7FFFFFFF;
    c.integ_gain   = 32'sh7FFFFFFF;
    c.deriv_weight = 32'sh7FFFFFFF;
    c.deriv_decay  = 25'd16777216;
    c.deriv_scale  = 31'h7FFFFFFF;
    c.windup_gain  = 32'sh7FFFFFFF;
    c.pitch_limit  = 31'h7FFFFFFF;
    c.hold_band    = 31'h7FFFFFFF;
    program_regs(c);
    add_random(90);
    drain();

    // Every register at its bottom value: empty zone, zero pitch limit.
    c.prop_gain    = 32'sh80000000;
    c.integ_gain   = 32'sh80000000;
    c.deriv_weight = 32'sh80000000;
    c.deriv_decay  = '0;
    c.deriv_scale  = '0;
    c.windup_gain  = 32'sh80000000;
    c.pitch_limit  = '0;
    c.hold_band    = '0;
    program_regs(c);
    add_random(60);
    drain();

    // Moderate random settings.
    repeat (3) begin
      program_regs(random_cfg());
      add_random(100);
      drain();
    end

    // Band equal to the margin leaves no zone; anti-windup off.
    c = random_cfg();
    c.windup_gain = 0;
    c.hold_band   = UGAIN_W'(MARGIN);
    program_regs(c);
    add_random(50);
    drain();

    // Closing stretch without any idling.
    quiet = 1'b1;
    program_regs(random_cfg());
    add_random(100);
    drain();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pitch_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
